// ===== sv/fcv_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fcv_pkg
// Shared types and constants for the FIX checksum validator.
// ---------------------------------------------------------------------------
package fcv_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_MATCH     = 2'd0,
    ST_MISMATCH  = 2'd1,
    ST_NO_TAG    = 2'd2,
    ST_NO_DIGITS = 2'd3
  } status_t;

  // Value decoder phases
  typedef enum logic [1:0] {
    PH_SIGN   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_STOP   = 2'd2
  } phase_t;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned VAL_W  = 10;
  localparam int unsigned CNT_W  = 2;

  // Characters of interest
  localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  // Sum of '1' and '0', removed when the tag completes
  localparam logic [BYTE_W-1:0] TAG_PREFIX_SUM = CH_ONE + CH_ZERO;

  // Bytes examined after a tag
  localparam logic [CNT_W-1:0] VALUE_CHARS = 2'd3;

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage
`default_nettype wire

// ===== sv/fcv_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fcv_if
// Valid/ready channels for message bytes in and check results out.
// ---------------------------------------------------------------------------
interface fcv_in_if;
  import fcv_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] msg_byte;
  logic              end_of_message;

  modport source (output valid, output msg_byte, output end_of_message, input ready);
  modport sink   (input valid, input msg_byte, input end_of_message, output ready);
endinterface

interface fcv_out_if;
  import fcv_pkg::*;

  logic              valid;
  logic              ready;
  status_t           status;
  logic [BYTE_W-1:0] computed_sum;
  logic [VAL_W-1:0]  expected_value;

  modport source (output valid, output status, output computed_sum, output expected_value,
                  input ready);
  modport sink   (input valid, input status, input computed_sum, input expected_value,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/fix_checksum_validator_core.sv =====
`default_nettype none
// Timing: a byte's transaction is registered in the input register, processed there and,
//   on the last byte, the result is registered once the result register is free.
// Throughput: one byte per cycle; non-final bytes keep flowing while a finished
//   result waits on out_stream.ready, and a final byte waits in the input
//   register until the result register is free.
// Reset: synchronous, active low; clears all message state and both valids.
// ---------------------------------------------------------------------------
// fix_checksum_validator_core
// Running mod-256 byte sum of a FIX message, "10=" tag detection and
// decoding of the checksum value; one status result per message.
// ---------------------------------------------------------------------------
module fix_checksum_validator_core (
  input  wire logic clk,
  input  wire logic rst_n,
  fcv_in_if.sink    in_stream,
  fcv_out_if.source out_stream
);
  import fcv_pkg::*;

  // Input register
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              s1_adv;
  logic              s1_fire;

  // Message state
  logic [BYTE_W-1:0] sum_r,      sum_nxt;
  logic [BYTE_W-1:0] prev1_r,    prev1_nxt;
  logic [BYTE_W-1:0] prev2_r,    prev2_nxt;
  logic              tag_seen_r, tag_seen_nxt;
  logic [BYTE_W-1:0] latched_r,  latched_nxt;
  logic [CNT_W-1:0]  chars_r,    chars_nxt;
  phase_t            phase_r,    phase_nxt;
  logic [VAL_W-1:0]  accum_r,    accum_nxt;
  logic              neg_r,      neg_nxt;
  logic              dseen_r,    dseen_nxt;

  // Updated values before end-of-message clear
  logic              tag_hit;
  logic              tag_u;
  logic [BYTE_W-1:0] latched_u;
  logic [CNT_W-1:0]  chars_u;
  phase_t            phase_u;
  logic [VAL_W-1:0]  accum_u;
  logic [VAL_W-1:0]  digit_val;
  logic              neg_u;
  logic              dseen_u;

  // Result
  logic              out_valid_r;
  status_t           status_r,   status_nxt;
  logic [BYTE_W-1:0] csum_r,     csum_nxt;
  logic [VAL_W-1:0]  expval_r,   expval_nxt;

  // Handshake: a non-final byte never needs the result slot
  assign s1_adv          = !out_valid_r || out_stream.ready || !s1_last_r;
  assign s1_fire         = s1_valid_r && s1_adv;
  assign in_stream.ready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_stream.ready) begin
      s1_valid_r <= in_stream.valid;
    end
    if (in_stream.valid && in_stream.ready) begin
      s1_byte_r <= in_stream.msg_byte;
      s1_last_r <= in_stream.end_of_message;
    end
  end

  // Tag detection, value decode and result formation
  always_comb begin
    tag_hit   = (s1_byte_r == CH_EQ) && (prev1_r == CH_ZERO) && (prev2_r == CH_ONE);
    tag_u     = tag_seen_r;
    latched_u = latched_r;
    chars_u   = chars_r;
    phase_u   = phase_r;
    accum_u   = accum_r;
    neg_u     = neg_r;
    dseen_u   = dseen_r;
    digit_val = VAL_W'(s1_byte_r - CH_ZERO);

    if (tag_hit) begin
      latched_u = sum_r - TAG_PREFIX_SUM;
      tag_u     = 1'b1;
      chars_u   = '0;
      phase_u   = PH_SIGN;
      accum_u   = '0;
      neg_u     = 1'b0;
      dseen_u   = 1'b0;
    end else if (tag_seen_r && (chars_r < VALUE_CHARS) && (phase_r != PH_STOP)) begin
      chars_u = chars_r + 1'b1;
      case (phase_r)
        PH_SIGN: begin
          if (is_blank(s1_byte_r)) begin
            phase_u = PH_SIGN;
          end else if ((s1_byte_r == CH_PLUS) || (s1_byte_r == CH_MINUS)) begin
            neg_u   = (s1_byte_r == CH_MINUS);
            phase_u = PH_DIGITS;
          end else if (is_digit(s1_byte_r)) begin
            accum_u = (accum_r << 3) + (accum_r << 1) + digit_val;
            dseen_u = 1'b1;
            phase_u = PH_DIGITS;
          end else begin
            phase_u = PH_STOP;
          end
        end
        PH_DIGITS: begin
          if (is_digit(s1_byte_r)) begin
            accum_u = (accum_r << 3) + (accum_r << 1) + digit_val;
            dseen_u = 1'b1;
          end else begin
            phase_u = PH_STOP;
          end
        end
        default: begin
          phase_u = PH_STOP;
        end
      endcase
    end

    // Status from the updated state
    status_nxt = ST_NO_TAG;
    csum_nxt   = '0;
    expval_nxt = '0;
    if (tag_u && !dseen_u) begin
      status_nxt = ST_NO_DIGITS;
      csum_nxt   = latched_u;
    end else if (tag_u) begin
      csum_nxt   = latched_u;
      expval_nxt = accum_u;
      if ((accum_u == VAL_W'(latched_u)) && (!neg_u || (accum_u == '0))) begin
        status_nxt = ST_MATCH;
      end else begin
        status_nxt = ST_MISMATCH;
      end
    end

    // Clear everything after the final byte
    if (s1_last_r) begin
      sum_nxt      = '0;
      prev1_nxt    = '0;
      prev2_nxt    = '0;
      tag_seen_nxt = 1'b0;
      latched_nxt  = '0;
      chars_nxt    = '0;
      phase_nxt    = PH_SIGN;
      accum_nxt    = '0;
      neg_nxt      = 1'b0;
      dseen_nxt    = 1'b0;
    end else begin
      sum_nxt      = sum_r + s1_byte_r;
      prev1_nxt    = s1_byte_r;
      prev2_nxt    = prev1_r;
      tag_seen_nxt = tag_u;
      latched_nxt  = latched_u;
      chars_nxt    = chars_u;
      phase_nxt    = phase_u;
      accum_nxt    = accum_u;
      neg_nxt      = neg_u;
      dseen_nxt    = dseen_u;
    end
  end

  // Message state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      prev1_r    <= '0;
      prev2_r    <= '0;
      tag_seen_r <= 1'b0;
      latched_r  <= '0;
      chars_r    <= '0;
      phase_r    <= PH_SIGN;
      accum_r    <= '0;
      neg_r      <= 1'b0;
      dseen_r    <= 1'b0;
    end else if (s1_fire) begin
      sum_r      <= sum_nxt;
      prev1_r    <= prev1_nxt;
      prev2_r    <= prev2_nxt;
      tag_seen_r <= tag_seen_nxt;
      latched_r  <= latched_nxt;
      chars_r    <= chars_nxt;
      phase_r    <= phase_nxt;
      accum_r    <= accum_nxt;
      neg_r      <= neg_nxt;
      dseen_r    <= dseen_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_fire && s1_last_r) begin
      status_r <= status_nxt;
      csum_r   <= csum_nxt;
      expval_r <= expval_nxt;
    end
  end

  assign out_stream.valid          = out_valid_r;
  assign out_stream.status         = status_r;
  assign out_stream.computed_sum   = csum_r;
  assign out_stream.expected_value = expval_r;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Byte-stream check of fix_checksum_validator_core: a directed table of short
// FIX messages, then random messages (well-formed, broken and noise) with
// random idling on both channels; results are scored against an in-bench
// checksum/tag decoder.
// ---------------------------------------------------------------------------
module testbench;
  import fcv_pkg::*;

  // One check result as seen on out_stream
  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] sum;
    logic [VAL_W-1:0]  value;
  } verdict_t;

  // Directed stimulus row: one byte, optionally with its result typed in
  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              eom;
    logic              typed;
    verdict_t          want;
  } dir_row_t;

  localparam int       DIR_ROWS     = 29;
  localparam int       ITEM_TARGET  = 1250;
  localparam int       IDLE_PCT     = 28;
  localparam int       HOLD_AFTER   = 15;   // results seen before the long hold
  localparam int       HOLD_CYCLES  = 64;
  localparam int       PAUSE_AT_MSG = 30;   // sender drains the block here
  localparam int       QUIET_LIMIT  = 1000;
  localparam int       DRAIN_CYCLES = 10;
  localparam verdict_t NO_CHECK     = '{ST_MATCH, 8'h00, 10'd0};

  // Directed table; typed results only where they are obvious
  dir_row_t dir_tab [DIR_ROWS] = '{
    // lone extremes, no tag
    '{8'h00,    1'b1, 1'b1, '{ST_NO_TAG,    8'h00, 10'd0}},
    '{8'hFF,    1'b1, 1'b1, '{ST_NO_TAG,    8'h00, 10'd0}},
    // tag on the final byte
    '{CH_ONE,   1'b0, 1'b0, NO_CHECK},
    '{CH_ZERO,  1'b0, 1'b0, NO_CHECK},
    '{CH_EQ,    1'b1, 1'b1, '{ST_NO_DIGITS, 8'h00, 10'd0}},
    // largest value
    '{CH_ONE,   1'b0, 1'b0, NO_CHECK},
    '{CH_ZERO,  1'b0, 1'b0, NO_CHECK},
    '{CH_EQ,    1'b0, 1'b0, NO_CHECK},
    '{CH_NINE,  1'b0, 1'b0, NO_CHECK},
    '{CH_NINE,  1'b0, 1'b0, NO_CHECK},
    '{CH_NINE,  1'b1, 1'b1, '{ST_MISMATCH,  8'h00, 10'd999}},
    // negative zero against a zero sum
    '{CH_ONE,   1'b0, 1'b0, NO_CHECK},
    '{CH_ZERO,  1'b0, 1'b0, NO_CHECK},
    '{CH_EQ,    1'b0, 1'b0, NO_CHECK},
    '{CH_MINUS, 1'b0, 1'b0, NO_CHECK},
    '{CH_ZERO,  1'b1, 1'b1, '{ST_MATCH,     8'h00, 10'd0}},
    // sign with no digits after it
    '{CH_CR,    1'b0, 1'b0, NO_CHECK},
    '{CH_ONE,   1'b0, 1'b0, NO_CHECK},
    '{CH_ZERO,  1'b0, 1'b0, NO_CHECK},
    '{CH_EQ,    1'b0, 1'b0, NO_CHECK},
    '{CH_PLUS,  1'b1, 1'b1, '{ST_NO_DIGITS, 8'h0D, 10'd0}},
    // repeated tag inside the digits, then whitespace and a digit
    '{CH_ONE,   1'b0, 1'b0, NO_CHECK},
    '{CH_ZERO,  1'b0, 1'b0, NO_CHECK},
    '{CH_EQ,    1'b0, 1'b0, NO_CHECK},
    '{CH_ONE,   1'b0, 1'b0, NO_CHECK},
    '{CH_ZERO,  1'b0, 1'b0, NO_CHECK},
    '{CH_EQ,    1'b0, 1'b0, NO_CHECK},
    '{CH_TAB,   1'b0, 1'b0, NO_CHECK},
    '{8'h32,    1'b1, 1'b0, NO_CHECK}
  };

  logic clk;
  logic rst_n;

  fcv_in_if  in_bus ();
  fcv_out_if out_bus ();

  fix_checksum_validator_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_bus),
    .out_stream (out_bus)
  );

  // Decoder state mirrored in the bench
  logic [BYTE_W-1:0] sum_all;
  logic [15:0]       prev_two;
  logic              tag_found;
  logic [BYTE_W-1:0] tag_sum;
  logic [CNT_W-1:0]  value_len;
  phase_t            value_phase;
  logic [VAL_W-1:0]  value_acc;
  logic              value_neg;
  logic              value_has_digit;

  verdict_t          pending_verdicts[$];
  logic [BYTE_W-1:0] msg_bytes[$];
  logic [BYTE_W-1:0] msg_sum;

  logic     typed_on;
  verdict_t typed_exp;
  int       errors       = 0;
  int       sent_cnt     = 0;
  int       results_seen = 0;
  int       quiet_cycles = 0;
  bit       hold_done    = 0;
  logic     calm;

  // No idling on either side inside this window
  assign calm = (sent_cnt >= 600) && (sent_cnt < 800);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  // Clear all message state, as after reset or a final byte
  function automatic void clear_checksum_state();
    sum_all         = '0;
    prev_two        = '0;
    tag_found       = 1'b0;
    tag_sum         = '0;
    value_len       = '0;
    value_phase     = PH_SIGN;
    value_acc       = '0;
    value_neg       = 1'b0;
    value_has_digit = 1'b0;
  endfunction

  // Advance the checksum/tag decoder by one byte; emits a verdict on the final byte
  function automatic void advance_checksum(input logic [BYTE_W-1:0] b, input logic last,
                                           output bit emits, output verdict_t res);
    bit blank;
    bit dec;
    blank = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    dec   = (b >= CH_ZERO) && (b <= CH_NINE);
    emits = 1'b0;
    res   = NO_CHECK;

    if (b == CH_EQ && prev_two == {CH_ONE, CH_ZERO}) begin
      // new tag: sum before the '1', decoder restarts
      tag_sum         = sum_all - CH_ONE - CH_ZERO;
      tag_found       = 1'b1;
      value_len       = '0;
      value_phase     = PH_SIGN;
      value_acc       = '0;
      value_neg       = 1'b0;
      value_has_digit = 1'b0;
    end else if (tag_found && value_len < VALUE_CHARS && value_phase != PH_STOP) begin
      value_len++;
      if (value_phase == PH_SIGN && blank) begin
        // leading whitespace uses up a character
      end else if (value_phase == PH_SIGN && (b == CH_PLUS || b == CH_MINUS)) begin
        value_neg   = (b == CH_MINUS);
        value_phase = PH_DIGITS;
      end else if (dec) begin
        value_acc       = VAL_W'(value_acc * 10 + (b - CH_ZERO));
        value_has_digit = 1'b1;
        value_phase     = PH_DIGITS;
      end else begin
        value_phase = PH_STOP;
      end
    end

    sum_all  = sum_all + b;
    prev_two = {prev_two[7:0], b};

    if (last) begin
      emits = 1'b1;
      if (!tag_found)
        res = '{ST_NO_TAG, 8'h00, 10'd0};
      else if (!value_has_digit)
        res = '{ST_NO_DIGITS, tag_sum, 10'd0};
      else
        res = '{status_t'(((value_acc == tag_sum) && (!value_neg || value_acc == 0)) ?
                ST_MATCH : ST_MISMATCH), tag_sum, value_acc};
      clear_checksum_state();
    end
  endfunction

  // Transaction monitor, scoreboard and watchdog
  always @(posedge clk) begin
    bit       emits;
    verdict_t res;
    verdict_t got;
    verdict_t want;
    bit       moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        moved = 1'b1;
        advance_checksum(in_bus.msg_byte, in_bus.end_of_message, emits, res);
        if (emits)
          pending_verdicts.push_back(typed_on ? typed_exp : res);
      end
      if (out_bus.valid && out_bus.ready) begin
        moved = 1'b1;
        results_seen++;
        got = '{out_bus.status, out_bus.computed_sum, out_bus.expected_value};
        if (pending_verdicts.size() == 0) begin
          flag_error($sformatf("unexpected result status %0d sum %0d value %0d",
                               got.status, got.sum, got.value));
        end else begin
          want = pending_verdicts.pop_front();
          if (got.status !== want.status)
            flag_error($sformatf("result %0d status %0d, want %0d",
                                 results_seen, got.status, want.status));
          if (got.sum !== want.sum)
            flag_error($sformatf("result %0d computed_sum %0d, want %0d",
                                 results_seen, got.sum, want.sum));
          if (got.value !== want.value)
            flag_error($sformatf("result %0d expected_value %0d, want %0d",
                                 results_seen, got.value, want.value));
        end
      end
      if (moved)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns timeout, %0d results outstanding", $time, pending_verdicts.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one byte, with random idling, until it is accepted
  task automatic drive_byte(input logic [BYTE_W-1:0] b, input logic last,
                            input logic typed, input verdict_t want);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.msg_byte       <= b;
    in_bus.end_of_message <= last;
    typed_on  = typed;
    typed_exp = want;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sent_cnt++;
  endtask

  task automatic put_byte(input logic [BYTE_W-1:0] c);
    msg_bytes.push_back(c);
    msg_sum = msg_sum + c;
  endtask

  // Value field after a tag: the true checksum or a random mix of characters
  task automatic put_value(input logic [BYTE_W-1:0] before_tag);
    int vlen;
    int cls;
    if ($urandom_range(99) < 40) begin
      put_byte(8'(CH_ZERO + before_tag / 100));
      put_byte(8'(CH_ZERO + (before_tag / 10) % 10));
      put_byte(8'(CH_ZERO + before_tag % 10));
    end else begin
      vlen = $urandom_range(5);
      repeat (vlen) begin
        cls = $urandom_range(9);
        case (cls)
          0:       put_byte(CH_SPACE);
          1:       put_byte(8'($urandom_range(CH_CR, CH_TAB)));
          2:       put_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
          9:       put_byte(8'($urandom));
          default: put_byte(8'(CH_ZERO + $urandom_range(9)));
        endcase
      end
    end
  endtask

  // Build one random message into msg_bytes
  task automatic build_message();
    int               kind;
    int               plen;
    int               ntags;
    logic [BYTE_W-1:0] before_tag;
    msg_bytes.delete();
    msg_sum = '0;
    kind = $urandom_range(99);

    // pure noise
    if (kind >= 85) begin
      plen = $urandom_range(10, 1);
      repeat (plen) put_byte(8'($urandom));
      return;
    end

    // header-like prefix, mostly printable
    plen = $urandom_range(12);
    repeat (plen)
      put_byte(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h7E, 8'h20)));

    if (kind >= 70 && kind < 78) begin
      // broken tag
      case ($urandom_range(2))
        0: begin put_byte(CH_ONE);  put_byte(CH_EQ); end
        1: begin put_byte(CH_ZERO); put_byte(CH_EQ); end
        default: begin
          put_byte(CH_ONE);
          put_byte(CH_ZERO);
          put_byte(8'($urandom_range(8'h3C, 8'h20)));
        end
      endcase
      put_value(msg_sum);
    end else begin
      ntags = ($urandom_range(9) == 0) ? 2 : 1;
      repeat (ntags) begin
        before_tag = msg_sum;
        put_byte(CH_ONE);
        put_byte(CH_ZERO);
        put_byte(CH_EQ);
        put_value(before_tag);
      end
    end

    if ($urandom_range(1))
      put_byte(8'h01);

    // truncated message: end mark lands anywhere
    if (kind >= 78)
      msg_bytes = msg_bytes[0:$urandom_range(msg_bytes.size() - 1)];
  endtask

  // Result receiver: random back-pressure plus one long hold
  initial begin
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Reset, stimulus and end of run
  initial begin
    int msg_cnt;
    msg_cnt = 0;
    in_bus.valid          = 1'b0;
    in_bus.msg_byte       = '0;
    in_bus.end_of_message = 1'b0;
    typed_on  = 1'b0;
    typed_exp = NO_CHECK;
    rst_n     = 1'b0;
    clear_checksum_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i])
      drive_byte(dir_tab[i].b, dir_tab[i].eom, dir_tab[i].typed, dir_tab[i].want);

    while (sent_cnt < ITEM_TARGET) begin
      msg_cnt++;
      if (msg_cnt == PAUSE_AT_MSG) begin
        // let the block drain completely before going on
        @(negedge clk);
        in_bus.valid <= 1'b0;
        wait (pending_verdicts.size() == 0);
      end
      build_message();
      foreach (msg_bytes[j])
        drive_byte(msg_bytes[j], j == msg_bytes.size() - 1, 1'b0, NO_CHECK);
    end

    @(negedge clk);
    in_bus.valid <= 1'b0;
    wait (pending_verdicts.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
